FILE: design/spnofb_pkg.sv
// Shared types, codes and bit-level helpers for the SPN OFB keystream unit.
// Used by the front end, the round core, the output stage and the top level.
package spnofb_pkg;

   // Item codes carried in the input tuser field
   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_KEYSTREAM = 2'd1,
      OP_RESTART   = 2'd2
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_KEY_WORD_0 = 2'd0,
      REG_KEY_WORD_1 = 2'd1,
      REG_KEY_WORD_2 = 2'd2,
      REG_KEY_WORD_3 = 2'd3
   } reg_index_type;

   localparam int BLOCK_W     = 128;
   localparam int HALF_W      = 64;
   localparam int BLOCK_BYTES = 16;
   localparam int BYTE_W      = 8;
   localparam int SBOX_DEPTH  = 256;
   localparam int KEY_W       = 208;
   // Key padded with zeros so that the final key of the longest schedule stays in range
   localparam int KEY_EXT_W   = 224;
   localparam int KEY_SEL_W   = 4;

   // One queued command between front end and core
   typedef struct packed {
      op_type     op;
      logic [7:0] sbox_index;
      logic [7:0] sbox_value;
   } cmd_type;

   // Bit transpose: out[16j+i] = in[8i+j], bit 0 is the most significant
   function automatic logic [BLOCK_W-1:0] transpose_bits(input logic [BLOCK_W-1:0] src);
      logic [BLOCK_W-1:0] dst;
      dst = '0;
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 8; j++) begin
            dst[BLOCK_W-1-(16*j+i)] = src[BLOCK_W-1-(8*i+j)];
         end
      end
      return dst;
   endfunction

   // Round key k (0-based): key bits 8k .. 8k+127, zero past the end of the key
   function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_EXT_W-1:0] key_ext,
                                                     input logic [KEY_SEL_W-1:0] k);
      logic [KEY_EXT_W-1:0] shifted;
      shifted = key_ext << {k, 3'b000};
      return shifted[KEY_EXT_W-1 -: BLOCK_W];
   endfunction

endpackage

FILE: design/spn_cipher_ofb_keystream_unit.sv
// SPN OFB keystream unit: a 128-bit substitution-permutation cipher in output
// feedback mode. Load the 256-byte S-box with op 0 items and the 208-bit key over
// the register port, then each op 1 item yields one 128-bit keystream block as two
// 64-bit results, high half first (tlast on the second); op 2 clears the feedback.
// The input side takes one item per cycle while its four-entry queue has room.
// A keystream block occupies the round core from taking the command, through one
// round at a time over the sixteen S-box memory lanes, to the final key, which
// waits for the output stage to take the block; each block needs the previous one
// as its feedback. Loads and restarts are taken only while the core is idle. The
// S-box has no reset: every entry used must be loaded first. Depends on spnofb_pkg.
module spn_cipher_ofb_keystream_unit #(
   parameter int ROUND_COUNT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [7:0] sbox_index, [15:8] sbox_value
   input  logic [1:0]  req_tuser,    // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] block_half
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import spnofb_pkg::*;

   logic [63:0]          key_word_0_ff;
   logic [63:0]          key_word_1_ff;
   logic [63:0]          key_word_2_ff;
   logic [15:0]          key_word_3_ff;
   logic                 csr_wr;
   reg_index_type        csr_idx;
   logic [KEY_EXT_W-1:0] key_ext;
   logic                 cmd_valid;
   logic                 cmd_ready;
   cmd_type              cmd;
   logic                 res_valid;
   logic                 res_ready;
   logic [BLOCK_W-1:0]   res_data;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_0_ff <= '0;
         key_word_1_ff <= '0;
         key_word_2_ff <= '0;
         key_word_3_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_KEY_WORD_0: key_word_0_ff <= csr_pwdata;
            REG_KEY_WORD_1: key_word_1_ff <= csr_pwdata;
            REG_KEY_WORD_2: key_word_2_ff <= csr_pwdata;
            REG_KEY_WORD_3: key_word_3_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_KEY_WORD_0: csr_prdata = key_word_0_ff;
         REG_KEY_WORD_1: csr_prdata = key_word_1_ff;
         REG_KEY_WORD_2: csr_prdata = key_word_2_ff;
         REG_KEY_WORD_3: csr_prdata = {48'd0, key_word_3_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Key bit 0 on top, zero padded past the last key bit
   assign key_ext = {key_word_0_ff, key_word_1_ff, key_word_2_ff, key_word_3_ff,
                     (KEY_EXT_W - KEY_W)'(0)};

   spnofb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   spnofb_core #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .key_ext   (key_ext),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   spnofb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_data   (res_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/spnofb_front.sv
// Front end of the SPN OFB keystream unit: accepts input items, drops unused
// codes and queues commands for the round core. Depends on spnofb_pkg.
module spnofb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [7:0] sbox_index, [15:8] sbox_value
   input  logic [1:0]           req_tuser,   // [1:0] op
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output spnofb_pkg::cmd_type  cmd
);
   import spnofb_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;

   cmd_type          q_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             accept;
   logic             keep;
   logic             push;
   logic             pop;
   cmd_type          new_cmd;

   // Classify the incoming item: only known codes enter the queue
   always_comb begin
      new_cmd.op         = op_type'(req_tuser);
      new_cmd.sbox_index = req_tdata[7:0];
      new_cmd.sbox_value = req_tdata[15:8];
      keep               = req_tuser inside {OP_LOAD, OP_KEYSTREAM, OP_RESTART};
   end

   assign req_tready = (cnt_ff != (PTR_W+1)'(DEPTH));
   assign accept     = req_tvalid & req_tready;
   assign push       = accept & keep;
   assign cmd_valid  = (cnt_ff != '0);
   assign pop        = cmd_valid & cmd_ready;
   assign cmd        = q_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the command payload
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: design/spnofb_core.sv
// Round core of the SPN OFB keystream unit: S-box loads, feedback restart and
// the round loop over sixteen S-box memory lanes. Depends on spnofb_pkg.
module spnofb_core #(
   parameter int ROUND_COUNT = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  spnofb_pkg::cmd_type               cmd,
   input  logic [spnofb_pkg::KEY_EXT_W-1:0]  key_ext,
   output logic                              res_valid,
   input  logic                              res_ready,
   output logic [spnofb_pkg::BLOCK_W-1:0]    res_data
);
   import spnofb_pkg::*;

   localparam int RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [RND_W-1:0]   rnd_ff, rnd_in;
   logic [BLOCK_W-1:0] fb_ff, fb_in;
   logic [BYTE_W-1:0]  sbox_rd_ff [BLOCK_BYTES];
   logic [BLOCK_W-1:0] sub_block;
   logic [BLOCK_W-1:0] round_src;
   logic [BLOCK_W-1:0] addr_block;
   logic [KEY_SEL_W-1:0] key_sel;
   logic [BLOCK_W-1:0] cur_key;
   logic               load_en;
   logic               rd_en;

   // Gather the registered lane outputs into one block, byte 0 on top
   always_comb begin
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         sub_block[BLOCK_W-1-BYTE_W*b -: BYTE_W] = sbox_rd_ff[b];
      end
   end

   // Round input: feedback for the first round, transposed S-box output after
   assign round_src  = (rnd_ff == '0) ? fb_ff : transpose_bits(sub_block);
   assign key_sel    = (state_ff == ST_FINISH) ? KEY_SEL_W'(ROUND_COUNT) : KEY_SEL_W'(rnd_ff);
   assign cur_key    = round_key(key_ext, key_sel);
   assign addr_block = round_src ^ cur_key;
   assign res_data   = sub_block ^ cur_key;

   assign cmd_ready  = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_FINISH);
   assign load_en    = cmd_valid & cmd_ready & (cmd.op == OP_LOAD);
   assign rd_en      = (state_ff == ST_RUN);

   // One S-box copy per byte lane; a load writes all copies
   for (genvar g = 0; g < BLOCK_BYTES; g++) begin : g_lane
      logic [BYTE_W-1:0] sbox_mem [SBOX_DEPTH];

      always_ff @(posedge clock) begin
         if (load_en) begin
            sbox_mem[cmd.sbox_index] <= cmd.sbox_value;
         end
         if (rd_en) begin
            sbox_rd_ff[g] <= sbox_mem[addr_block[BLOCK_W-1-BYTE_W*g -: BYTE_W]];
         end
      end
   end

   // Sequence commands and rounds
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      fb_in    = fb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_KEYSTREAM: begin
                     state_in = ST_RUN;
                     rnd_in   = '0;
                  end
                  OP_RESTART: begin
                     fb_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (rnd_ff == RND_W'(ROUND_COUNT - 1)) begin
               state_in = ST_FINISH;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (res_ready) begin
               fb_in    = res_data;
               state_in = ST_IDLE;
               rnd_in   = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         fb_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         fb_ff    <= fb_in;
      end
   end

   // A finished block only follows the round loop
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ($past(state_ff) == ST_RUN || $past(state_ff) == ST_FINISH))
      else $error("finish entered without running rounds");

   // The last round issue leads straight to finish
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && rnd_ff == RND_W'(ROUND_COUNT - 1)) |=> (state_ff == ST_FINISH))
      else $error("round loop overran");

   // Feedback changes only on a delivered block or a restart
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |=> $stable(fb_ff))
      else $error("feedback changed during rounds");

endmodule

FILE: design/spnofb_out.sv
// Output stage of the SPN OFB keystream unit: holds one finished block and
// sends it as two 64-bit halves, high half first. Depends on spnofb_pkg.
module spnofb_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            res_valid,
   output logic                            res_ready,
   input  logic [spnofb_pkg::BLOCK_W-1:0]  res_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [spnofb_pkg::HALF_W-1:0]   rsp_tdata,
   output logic                            rsp_tlast
);
   import spnofb_pkg::*;

   logic [BLOCK_W-1:0] data_ff;
   logic               valid_ff, valid_in;
   logic               half_ff, half_in;
   logic               take;
   logic               sent;

   assign sent       = valid_ff & rsp_tready;
   assign res_ready  = !valid_ff || (sent && half_ff);
   assign take       = res_valid & res_ready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = half_ff;
   assign rsp_tdata  = half_ff ? data_ff[HALF_W-1:0] : data_ff[BLOCK_W-1 -: HALF_W];

   // Step through the halves, reload on a new block
   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      if (sent) begin
         if (half_ff) begin
            valid_in = 1'b0;
            half_in  = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end
      if (take) begin
         valid_in = 1'b1;
         half_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= res_data;
      end
   end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the SPN OFB keystream unit: loads the S-box, writes the key over
// the register port and checks every keystream half against an in-bench cipher model.
// Depends on spnofb_pkg and spn_cipher_ofb_keystream_unit.
`timescale 1ns / 100ps

module testbench;
   import spnofb_pkg::*;

   localparam int ROUNDS = 10;
   // Worst-case drain of the input queue with the core busy
   localparam int SETTLE_CYCLES = 4 * (ROUNDS + 2) + 8;
   localparam int TIMEOUT_NS = 5_000_000;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int RANDOM_PHASES = 6;
   localparam int MAX_PRINTED = 50;

   // Op code the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Receiver stall patterns
   localparam int RX_STEADY = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_SLOW   = 2;

   typedef struct packed {
      logic [63:0] block_half;
      logic        last_half;
   } half_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [7:0] sbox_index, [15:8] sbox_value
   logic [1:0]  req_tuser = '0;    // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [63:0] block_half
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // Cipher state mirrored by the bench
   logic [7:0]  sbox_mem [256];
   logic [63:0] key_word [4] = '{default: '0};
   logic [63:0] fb_hi = '0;
   logic [63:0] fb_lo = '0;
   half_type    pending_halves [$];

   int mismatch_count = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;

   spn_cipher_ofb_keystream_unit #(
      .ROUND_COUNT(ROUNDS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Encrypt one feedback block with the current key and S-box
   function automatic logic [127:0] spn_encrypt(input logic [127:0] feedback);
      logic [7:0]   kb [48];
      logic [7:0]   w [16];
      logic [7:0]   v [16];
      logic [127:0] block;
      int           from_bit;
      int           to_bit;
      for (int b = 0; b < 48; b++) kb[b] = 8'h00;
      for (int b = 0; b < 8; b++) begin
         kb[b]      = key_word[0][63-8*b -: 8];
         kb[8 + b]  = key_word[1][63-8*b -: 8];
         kb[16 + b] = key_word[2][63-8*b -: 8];
      end
      kb[24] = key_word[3][15:8];
      kb[25] = key_word[3][7:0];
      for (int b = 0; b < 16; b++) begin
         w[b] = feedback[127-8*b -: 8];
         v[b] = 8'h00;
      end
      for (int r = 1; r <= ROUNDS; r++) begin
         for (int b = 0; b < 16; b++) v[b] = sbox_mem[w[b] ^ kb[r - 1 + b]];
         // bit transpose, bit 0 is the msb of byte 0
         for (int b = 0; b < 16; b++) w[b] = 8'h00;
         for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 8; j++) begin
               from_bit = 8 * i + j;
               to_bit   = 16 * j + i;
               w[to_bit / 8][7 - to_bit % 8] = v[from_bit / 8][7 - from_bit % 8];
            end
         end
      end
      for (int b = 0; b < 16; b++) block[127-8*b -: 8] = v[b] ^ kb[ROUNDS + b];
      return block;
   endfunction

   // Update the mirrored state for one accepted item
   task automatic apply_item(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] val);
      logic [127:0] block;
      case (op)
         OP_LOAD: begin
            sbox_mem[idx] = val;
         end
         OP_KEYSTREAM: begin
            block = spn_encrypt({fb_hi, fb_lo});
            fb_hi = block[127:64];
            fb_lo = block[63:0];
            pending_halves.push_back('{block_half: block[127:64], last_half: 1'b0});
            pending_halves.push_back('{block_half: block[63:0], last_half: 1'b1});
         end
         OP_RESTART: begin
            fb_hi = '0;
            fb_lo = '0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   // Check results, then track accepted items and register accesses
   always @(posedge clock) begin
      half_type head;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_halves.size() == 0) begin
               report_mismatch("result with no block pending", rsp_tdata, '0);
            end else begin
               head = pending_halves.pop_front();
               if (rsp_tdata !== head.block_half)
                  report_mismatch("block_half", rsp_tdata, head.block_half);
               if (rsp_tlast !== head.last_half)
                  report_mismatch("last_half", 64'(rsp_tlast), 64'(head.last_half));
            end
         end
         if (req_tvalid && req_tready)
            apply_item(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[4:3] == REG_KEY_WORD_3)
                  key_word[csr_paddr[4:3]] = {48'h0, csr_pwdata[15:0]};
               else
                  key_word[csr_paddr[4:3]] = csr_pwdata;
            end else if (csr_prdata !== key_word[csr_paddr[4:3]]) begin
               report_mismatch("register read", csr_prdata, key_word[csr_paddr[4:3]]);
            end
         end
      end
   end

   // Receiver: switch between random stall patterns
   always @(negedge clock) begin
      int rx_mode;
      int rx_left;
      if (rx_left <= 0) begin
         rx_mode = $urandom_range(RX_STEADY, RX_SLOW);
         rx_left = $urandom_range(50, 400);
      end
      rx_left--;
      case (rx_mode)
         RX_STEADY: rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         default:   rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Send one item; enter and leave at a falling edge
   task automatic send_item(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] val);
      int gap;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {val, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
   endtask

   // Hold off until every block has come out and the core is quiet
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_halves.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input logic write,
                             input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write the whole key and read every word back
   task automatic set_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [15:0] k3);
      csr_access(REG_KEY_WORD_0, 1'b1, k0);
      csr_access(REG_KEY_WORD_1, 1'b1, k1);
      csr_access(REG_KEY_WORD_2, 1'b1, k2);
      csr_access(REG_KEY_WORD_3, 1'b1, {48'h0, k3});
      csr_access(REG_KEY_WORD_0, 1'b0, '0);
      csr_access(REG_KEY_WORD_1, 1'b0, '0);
      csr_access(REG_KEY_WORD_2, 1'b0, '0);
      csr_access(REG_KEY_WORD_3, 1'b0, '0);
   endtask

   // Fill every S-box entry, with the extremes at both ends
   task automatic test_sbox_fill();
      send_item(OP_LOAD, 8'd0, 8'hFF);
      for (int i = 1; i < 255; i++) send_item(OP_LOAD, 8'(i), 8'($urandom));
      send_item(OP_LOAD, 8'd255, 8'h00);
      wait_drain();
   endtask

   // Blocks from the reset key, restart and the unused code
   task automatic test_reset_key();
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      send_item(OP_KEYSTREAM, 8'hFF, 8'hFF);
      send_item(OP_UNUSED, 8'hFF, 8'hFF);
      send_item(OP_RESTART, 8'h00, 8'hFF);
      send_item(OP_KEYSTREAM, 8'h5A, 8'hA5);
      send_item(OP_UNUSED, 8'h00, 8'h00);
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      wait_drain();
   endtask

   // Extreme and mixed keys through the register port
   task automatic test_register_access();
      set_key('1, '1, '1, 16'hFFFF);
      send_item(OP_RESTART, 8'h00, 8'h00);
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      wait_drain();
      set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
              64'hA5A5_5A5A_F00F_0FF0, 16'h8001);
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      wait_drain();
   endtask

   // S-box loads at the extremes between blocks, back to back without gaps
   task automatic test_load_between_blocks();
      gaps_on = 1'b0;
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      send_item(OP_LOAD, 8'd255, 8'hFF);
      send_item(OP_LOAD, 8'd0, 8'h00);
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      send_item(OP_RESTART, 8'hFF, 8'h00);
      send_item(OP_UNUSED, 8'h55, 8'hAA);
      send_item(OP_KEYSTREAM, 8'h00, 8'h00);
      wait_drain();
      gaps_on = 1'b1;
   endtask

   // Random mix of blocks, loads, restarts and unused codes over several keys
   task automatic test_random_traffic();
      int sent;
      int pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       set_key('1, '1, '1, 16'hFFFF);
            1:       set_key('0, '0, '0, 16'h0000);
            default: set_key({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, 16'($urandom));
         endcase
         gaps_on = (phase % 3 != 0);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_item(OP_KEYSTREAM, 8'($urandom), 8'($urandom));
               sent++;
            end else if (pick < 80) begin
               send_item(OP_LOAD, 8'($urandom), 8'($urandom));
               sent++;
            end else if (pick < 90) begin
               send_item(OP_RESTART, 8'($urandom), 8'($urandom));
               sent++;
            end else begin
               send_item(OP_UNUSED, 8'($urandom), 8'($urandom));
            end
         end
         wait_drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_sbox_fill();
      test_reset_key();
      test_register_access();
      test_load_between_blocks();
      test_random_traffic();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
design/spnofb_pkg.sv
design/spnofb_front.sv
design/spnofb_core.sv
design/spnofb_out.sv
design/spn_cipher_ofb_keystream_unit.sv
bench/testbench.sv
